### rtl/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// shared types, codes and helpers of the set-associative lru tag store
// ----------------------------------------------------------------------------
package salc_pkg;

    localparam int MODE_W       = 2;
    localparam int OUTCOME_W    = 2;
    localparam int COUNT_W      = 32;
    localparam int SET_BITS_W   = 3;
    localparam int BLOCK_BITS_W = 5;
    localparam int WAYS_USED_W  = 4;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 4;
    localparam int REG_IDX_W    = 2;

    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [OUTCOME_W-1:0] t_outcome;
    typedef logic [COUNT_W-1:0]   t_count;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    // access kinds
    localparam t_mode MODE_INSTR  = 2'd0;
    localparam t_mode MODE_LOAD   = 2'd1;
    localparam t_mode MODE_STORE  = 2'd2;
    localparam t_mode MODE_MODIFY = 2'd3;

    // lookup outcomes
    localparam t_outcome OC_HIT   = 2'd0;
    localparam t_outcome OC_FILL  = 2'd1;
    localparam t_outcome OC_EVICT = 2'd2;

    // register indexes
    localparam t_reg_idx REG_SET_BITS   = 2'd0;
    localparam t_reg_idx REG_BLOCK_BITS = 2'd1;
    localparam t_reg_idx REG_WAYS_USED  = 2'd2;

    localparam t_count COUNT_MAX = 32'hffff_ffff;

    typedef struct packed {
        logic [SET_BITS_W-1:0]   set_bits;
        logic [BLOCK_BITS_W-1:0] block_bits;
        logic [WAYS_USED_W-1:0]  ways_used;
    } t_cfg;

    // status of one lookup
    typedef struct packed {
        t_outcome outcome;
        logic     hit;
        logic     evict;
    } t_lkp;

    typedef struct packed {
        t_outcome outcome;
        t_count   hit_total;
        t_count   miss_total;
        t_count   eviction_total;
        logic     last;
    } t_result;

    function automatic t_count sat_inc(input t_count v);
        t_count r;
        r = (v == COUNT_MAX) ? v : v + t_count'(1);
        return r;
    endfunction

endpackage

### rtl/salc_item_if.sv
// ----------------------------------------------------------------------------
// salc_item_if
// trace access channel: valid/ready with access kind and byte address
// ----------------------------------------------------------------------------
interface salc_item_if #(
    parameter int ADDR_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           mode;
    logic [ADDR_BITS-1:0] address;

    modport source (output valid, output mode, output address, input ready);
    modport sink   (input valid, input mode, input address, output ready);
endinterface

### rtl/salc_result_if.sv
// ----------------------------------------------------------------------------
// salc_result_if
// lookup result channel: valid/ready with outcome and running counts
// ----------------------------------------------------------------------------
interface salc_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  outcome;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] eviction_total;
    logic        last;

    modport source (
        output valid, output outcome, output hit_total, output miss_total,
        output eviction_total, output last, input ready
    );
    modport sink (
        input valid, input outcome, input hit_total, input miss_total,
        input eviction_total, input last, output ready
    );
endinterface

### rtl/set_assoc_lru_cache_tags.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags
// tag store of a set-associative cache with true lru replacement
// ----------------------------------------------------------------------------
//
//  channel    dir   handshake            payload
//  ---------  ----  -------------------  -------------------------------------
//  i_item     in    valid/ready          mode, address
//  o_result   out   valid/ready          outcome, hit_total, miss_total,
//                                        eviction_total, last
//  apb        in    psel/penable/pready  paddr, pwdata, pwrite / prdata
//
//  a load or store gives one result, a modify two (its two results leave the
//  output register one after the other); an instruction fetch gives none;
//  after an item is taken, its first result passes the set row read, then
//  the lookup and result register; a back-to-back item on the same set gets
//  the freshly written row through the ram bypass
//  reset clears control, counters and the per-set row flags at once, so no
//  clearing sweep runs and items are taken in the first cycle after reset
//  a stalled o_result holds the lookup stage; one more item still enters
//
module set_assoc_lru_cache_tags #(
    parameter int MAX_SETS  = 64,
    parameter int WAYS      = 8,
    parameter int ADDR_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    salc_item_if.sink                       i_item,
    salc_result_if.source                   o_result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [salc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [salc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [salc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import salc_pkg::*;

    // largest set-bit count whose set count fits in MAX_SETS, capped at 12
    function automatic int set_limit(input int sets);
        int lim;
        lim = 0;
        while ((lim < 12) && ((1 << (lim + 1)) <= sets)) begin
            lim++;
        end
        return lim;
    endfunction

    localparam int SET_LIM = set_limit(MAX_SETS);
    localparam int IDX_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int RANK_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int NW_W    = $clog2(WAYS + 1);
    localparam int ROW_W   = WAYS * (1 + ADDR_BITS + RANK_W);

    // configuration registers
    t_cfg r_cfg;

    // lookup stage
    logic                 r_a_v;
    logic                 r_a_mod;
    logic [IDX_W-1:0]     r_a_set;
    logic [ADDR_BITS-1:0] r_a_tag;

    // counters
    t_count r_hits;
    t_count r_misses;
    t_count r_evicts;

    // output register and the second result of a modify
    logic    r_out_v;
    t_result r_out;
    logic    r_pend_v;
    t_result r_pend;

    logic                          cfg_wr;
    t_reg_idx                      reg_idx;
    logic                          in_acc;
    logic                          rd_en;
    logic                          out_free;
    logic                          adv_a;
    logic [3:0]                    sb;
    logic [5:0]                    tag_sh;
    logic [ADDR_BITS-1:0]          addr_sh;
    logic [IDX_W-1:0]              set_idx;
    logic [ADDR_BITS-1:0]          tag_in;
    logic [NW_W-1:0]               nw;
    logic [WAYS-1:0]               way_mask;
    logic [ROW_W-1:0]              rd_row;
    logic [ROW_W-1:0]              wr_row;
    logic [WAYS-1:0]               rd_valid;
    logic [WAYS-1:0][ADDR_BITS-1:0] rd_tags;
    logic [WAYS-1:0][RANK_W-1:0]   rd_ranks;
    logic [WAYS-1:0]               wr_valid;
    logic [WAYS-1:0][ADDR_BITS-1:0] wr_tags;
    logic [WAYS-1:0][RANK_W-1:0]   wr_ranks;
    t_lkp                          lkp;
    t_count                        n_hits1;
    t_count                        n_hits2;
    t_count                        n_misses;
    t_count                        n_evicts;

    // ---------------- apb port ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_bits   <= '0;
            r_cfg.block_bits <= '0;
            r_cfg.ways_used  <= WAYS_USED_W'(1);
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_SET_BITS:   r_cfg.set_bits   <= pwdata[SET_BITS_W-1:0];
                REG_BLOCK_BITS: r_cfg.block_bits <= pwdata[BLOCK_BITS_W-1:0];
                REG_WAYS_USED:  r_cfg.ways_used  <= pwdata[WAYS_USED_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SET_BITS:   prdata = APB_DATA_W'(r_cfg.set_bits);
            REG_BLOCK_BITS: prdata = APB_DATA_W'(r_cfg.block_bits);
            REG_WAYS_USED:  prdata = APB_DATA_W'(r_cfg.ways_used);
            default:        prdata = '0;
        endcase
    end

    // ---------------- effective geometry ----------------
    // set bits saturate at what the set storage holds
    assign sb = (r_cfg.set_bits > SET_LIM) ? 4'(SET_LIM) : {1'b0, r_cfg.set_bits};

    always_comb begin
        if (r_cfg.ways_used == '0) begin
            nw = NW_W'(1);
        end else if (r_cfg.ways_used > WAYS) begin
            nw = NW_W'(WAYS);
        end else begin
            nw = NW_W'(r_cfg.ways_used);
        end
        for (int j = 0; j < WAYS; j++) begin
            way_mask[j] = (NW_W'(j) < nw);
        end
    end

    // address split: offset, set index, tag
    assign addr_sh = i_item.address >> r_cfg.block_bits;
    assign set_idx = IDX_W'(addr_sh) & ~({IDX_W{1'b1}} << sb);
    assign tag_sh  = {1'b0, r_cfg.block_bits} + {2'b00, sb};
    assign tag_in  = i_item.address >> tag_sh;

    // ---------------- handshake ----------------
    assign out_free     = !r_pend_v && (!r_out_v || o_result.ready);
    assign adv_a        = r_a_v && out_free;
    assign i_item.ready = !r_a_v || adv_a;
    assign in_acc       = i_item.valid && i_item.ready;
    // instruction fetches are taken and dropped here
    assign rd_en        = in_acc && (i_item.mode != MODE_INSTR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (i_item.ready) begin
            r_a_v <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_a_mod <= (i_item.mode == MODE_MODIFY);
            r_a_set <= set_idx;
            r_a_tag <= tag_in;
        end
    end

    // ---------------- set storage and lookup ----------------
    salc_tag_ram #(
        .DEPTH (MAX_SETS),
        .ROW_W (ROW_W)
    ) u_ram (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (rd_en),
        .i_rd_idx (set_idx),
        .i_wr_en  (adv_a),
        .i_wr_idx (r_a_set),
        .i_wr_row (wr_row),
        .o_rd_row (rd_row)
    );

    assign {rd_valid, rd_tags, rd_ranks} = rd_row;
    assign wr_row = {wr_valid, wr_tags, wr_ranks};

    salc_lookup #(
        .WAYS      (WAYS),
        .ADDR_BITS (ADDR_BITS),
        .RANK_W    (RANK_W)
    ) u_lookup (
        .i_way_mask (way_mask),
        .i_valid    (rd_valid),
        .i_tags     (rd_tags),
        .i_ranks    (rd_ranks),
        .i_tag      (r_a_tag),
        .o_valid    (wr_valid),
        .o_tags     (wr_tags),
        .o_ranks    (wr_ranks),
        .o_res      (lkp)
    );

    // ---------------- counters ----------------
    // the second lookup of a modify always hits the line just touched and
    // leaves the ranks alone, so only the hit count moves again
    assign n_hits1  = lkp.hit   ? sat_inc(r_hits)   : r_hits;
    assign n_misses = lkp.hit   ? r_misses          : sat_inc(r_misses);
    assign n_evicts = lkp.evict ? sat_inc(r_evicts) : r_evicts;
    assign n_hits2  = sat_inc(n_hits1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits   <= '0;
            r_misses <= '0;
            r_evicts <= '0;
        end else if (adv_a) begin
            r_hits   <= r_a_mod ? n_hits2 : n_hits1;
            r_misses <= n_misses;
            r_evicts <= n_evicts;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else if (adv_a) begin
            r_out_v  <= 1'b1;
            r_pend_v <= r_a_mod;
        end else if (o_result.ready) begin
            r_out_v  <= r_pend_v;
            r_pend_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_out.outcome         <= lkp.outcome;
            r_out.hit_total       <= n_hits1;
            r_out.miss_total      <= n_misses;
            r_out.eviction_total  <= n_evicts;
            r_out.last            <= !r_a_mod;
            r_pend.outcome        <= OC_HIT;
            r_pend.hit_total      <= n_hits2;
            r_pend.miss_total     <= n_misses;
            r_pend.eviction_total <= n_evicts;
            r_pend.last           <= 1'b1;
        end else if (o_result.ready && r_pend_v) begin
            r_out <= r_pend;
        end
    end

    assign o_result.valid          = r_out_v;
    assign o_result.outcome        = r_out.outcome;
    assign o_result.hit_total      = r_out.hit_total;
    assign o_result.miss_total     = r_out.miss_total;
    assign o_result.eviction_total = r_out.eviction_total;
    assign o_result.last           = r_out.last;

`ifndef ASSERT_OFF
    // the second result of a modify waits only behind its first
    a_pend_behind_first: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_out_v && !r_out.last)
    ) else $error("second modify result without a first one in front");

    // an eviction only happens with every in-use way of the set valid
    a_evict_full_set: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (adv_a && lkp.evict) |-> ((rd_valid & way_mask) == way_mask)
    ) else $error("eviction chosen while an in-use way is empty");

    // an eviction reported on the output implies a nonzero eviction count
    a_evict_counted: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && (r_out.outcome == OC_EVICT)) |-> (r_out.eviction_total != '0)
    ) else $error("eviction reported with zero eviction count");

    // hit count never goes back
    a_hits_monotonic: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_hits >= $past(r_hits))
    ) else $error("hit count decreased");
`endif

endmodule

### rtl/salc_tag_ram.sv
// ----------------------------------------------------------------------------
// salc_tag_ram
// one row per set, registered read, per-row valid flags, write bypass
// ----------------------------------------------------------------------------
module salc_tag_ram #(
    parameter int DEPTH = 64,
    parameter int ROW_W = 288
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_idx,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_idx,
    input  logic [ROW_W-1:0]                       i_wr_row,
    output logic [ROW_W-1:0]                       o_rd_row
);
    logic [ROW_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_row_ok;
    logic [ROW_W-1:0] r_q;
    logic [ROW_W-1:0] r_byp_row;
    logic             r_byp;
    logic             r_zero;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_row;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_idx];
        end
    end

    // row flags: a row never written reads as all zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
        end else if (i_wr_en) begin
            r_row_ok[i_wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_byp     <= i_wr_en && (i_wr_idx == i_rd_idx);
            r_byp_row <= i_wr_row;
            r_zero    <= !r_row_ok[i_rd_idx];
        end
    end

    assign o_rd_row = r_byp ? r_byp_row : (r_zero ? '0 : r_q);
endmodule

### rtl/salc_lookup.sv
// ----------------------------------------------------------------------------
// salc_lookup
// tag compare over one set, fill/victim choice and lru rank update
// ----------------------------------------------------------------------------
module salc_lookup #(
    parameter int WAYS      = 8,
    parameter int ADDR_BITS = 32,
    parameter int RANK_W    = 3
) (
    input  logic [WAYS-1:0]                 i_way_mask,
    input  logic [WAYS-1:0]                 i_valid,
    input  logic [WAYS-1:0][ADDR_BITS-1:0]  i_tags,
    input  logic [WAYS-1:0][RANK_W-1:0]     i_ranks,
    input  logic [ADDR_BITS-1:0]            i_tag,
    output logic [WAYS-1:0]                 o_valid,
    output logic [WAYS-1:0][ADDR_BITS-1:0]  o_tags,
    output logic [WAYS-1:0][RANK_W-1:0]     o_ranks,
    output salc_pkg::t_lkp                  o_res
);
    import salc_pkg::*;

    localparam int              WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);

    logic [WAYS-1:0]   hit_vec;
    logic [WAYS-1:0]   inv_vec;
    logic [WAY_W-1:0]  hit_way;
    logic [WAY_W-1:0]  inv_way;
    logic [WAY_W-1:0]  vic_way;
    logic [WAY_W-1:0]  sel_way;
    logic [RANK_W-1:0] lim;
    logic              age_all;

    always_comb begin
        for (int j = 0; j < WAYS; j++) begin
            hit_vec[j] = i_way_mask[j] && i_valid[j] && (i_tags[j] == i_tag);
            inv_vec[j] = i_way_mask[j] && !i_valid[j];
        end

        // lowest way wins
        hit_way = '0;
        inv_way = '0;
        for (int j = WAYS - 1; j >= 0; j--) begin
            if (hit_vec[j]) begin
                hit_way = WAY_W'(j);
            end
            if (inv_vec[j]) begin
                inv_way = WAY_W'(j);
            end
        end

        // largest rank, ties to the lowest way
        vic_way = '0;
        for (int j = 1; j < WAYS; j++) begin
            if (i_way_mask[j] && (i_ranks[j] > i_ranks[vic_way])) begin
                vic_way = WAY_W'(j);
            end
        end

        if (|hit_vec) begin
            sel_way     = hit_way;
            lim         = i_ranks[hit_way];
            age_all     = 1'b0;
            o_res.outcome = OC_HIT;
        end else if (|inv_vec) begin
            sel_way     = inv_way;
            lim         = '0;
            age_all     = 1'b1;
            o_res.outcome = OC_FILL;
        end else begin
            sel_way     = vic_way;
            lim         = i_ranks[vic_way];
            age_all     = 1'b0;
            o_res.outcome = OC_EVICT;
        end
        o_res.hit   = |hit_vec;
        o_res.evict = !(|hit_vec) && !(|inv_vec);

        o_valid = i_valid;
        o_tags  = i_tags;
        o_ranks = i_ranks;
        for (int j = 0; j < WAYS; j++) begin
            if ((WAY_W'(j) != sel_way) && i_way_mask[j] && i_valid[j]
                    && (age_all || (i_ranks[j] < lim)) && (i_ranks[j] < RANK_MAX)) begin
                o_ranks[j] = i_ranks[j] + RANK_W'(1);
            end
        end
        o_valid[sel_way] = 1'b1;
        o_tags[sel_way]  = i_tag;
        o_ranks[sel_way] = '0;
    end
endmodule

### dv/salc_lru_checker.sv
// ----------------------------------------------------------------------------
// salc_lru_checker
// watches the trace and result channels and the register port, keeps its own
// copy of the tag store, predicts every lookup and compares field by field
// ----------------------------------------------------------------------------
module salc_lru_checker #(
    parameter int MAX_SETS = 64,
    parameter int WAYS     = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    salc_item_if                            item_ch,
    salc_result_if                          res_ch,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic                            i_pready,
    input  logic [salc_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [salc_pkg::APB_DATA_W-1:0] i_pwdata,
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_checked,
    output salc_pkg::t_count                o_hits,
    output salc_pkg::t_count                o_misses,
    output salc_pkg::t_count                o_evictions
);
    import salc_pkg::*;

    localparam int LINES    = MAX_SETS * WAYS;
    // largest set-bit count whose set count still fits
    localparam int SB_LIMIT = $clog2(MAX_SETS + 1) - 1;

    logic [SET_BITS_W-1:0]   set_bits_q;
    logic [BLOCK_BITS_W-1:0] block_bits_q;
    logic [WAYS_USED_W-1:0]  ways_q;

    logic        line_ok   [LINES];
    logic [63:0] line_tagm [LINES];
    int unsigned line_rank [LINES];

    t_count  hits_q;
    t_count  misses_q;
    t_count  evicts_q;
    t_result expected_lookups [$];
    int      errors;
    int      checked;

    function automatic int unsigned active_ways();
        if (ways_q == 0) return 1;
        if (ways_q > WAYS) return WAYS;
        return ways_q;
    endfunction

    // way becomes most recent, valid ways younger than rank_lim age by one
    function automatic void refresh_rank(input int unsigned base, nw, way, rank_lim);
        for (int j = 0; j < nw; j++) begin
            if (j != way && line_ok[base+j] && line_rank[base+j] < rank_lim &&
                line_rank[base+j] < WAYS - 1)
                line_rank[base+j]++;
        end
        line_rank[base+way] = 0;
    endfunction

    function automatic t_outcome cache_access(input logic [31:0] addr);
        int unsigned sb;
        int unsigned bb;
        int unsigned nw;
        int unsigned base;
        int unsigned victim;
        logic [63:0] wide;
        logic [63:0] set_v;
        logic [63:0] tag_v;
        sb     = (set_bits_q > SB_LIMIT) ? SB_LIMIT : set_bits_q;
        bb     = block_bits_q;
        nw     = active_ways();
        wide   = {32'd0, addr};
        set_v  = (wide >> bb) & ((64'd1 << sb) - 64'd1);
        tag_v  = wide >> (bb + sb);
        base   = 32'(set_v) * WAYS;
        for (int j = 0; j < nw; j++) begin
            if (line_ok[base+j] && line_tagm[base+j] == tag_v) begin
                refresh_rank(base, nw, j, line_rank[base+j]);
                hits_q = sat_inc(hits_q);
                return OC_HIT;
            end
        end
        misses_q = sat_inc(misses_q);
        for (int j = 0; j < nw; j++) begin
            if (!line_ok[base+j]) begin
                line_ok[base+j]   = 1'b1;
                line_tagm[base+j] = tag_v;
                refresh_rank(base, nw, j, WAYS);
                return OC_FILL;
            end
        end
        // oldest way, lowest index wins a tie
        victim = 0;
        for (int j = 1; j < nw; j++) begin
            if (line_rank[base+j] > line_rank[base+victim]) victim = j;
        end
        line_tagm[base+victim] = tag_v;
        refresh_rank(base, nw, victim, line_rank[base+victim]);
        evicts_q = sat_inc(evicts_q);
        return OC_EVICT;
    endfunction

    function automatic void flag(input string msg);
        errors++;
        if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    always @(posedge i_clk) begin : watch
        t_result  want;
        t_result  got;
        t_reg_idx idx;
        int       n;
        if (!i_rst_n) begin
            set_bits_q   = '0;
            block_bits_q = '0;
            ways_q       = WAYS_USED_W'(1);
            for (int k = 0; k < LINES; k++) begin
                line_ok[k]   = 1'b0;
                line_tagm[k] = '0;
                line_rank[k] = 0;
            end
            hits_q   = '0;
            misses_q = '0;
            evicts_q = '0;
            expected_lookups.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                idx = t_reg_idx'(i_paddr >> 2);
                case (idx)
                    REG_SET_BITS:   set_bits_q   = i_pwdata[SET_BITS_W-1:0];
                    REG_BLOCK_BITS: block_bits_q = i_pwdata[BLOCK_BITS_W-1:0];
                    REG_WAYS_USED:  ways_q       = i_pwdata[WAYS_USED_W-1:0];
                    default: ;
                endcase
            end

            if (item_ch.valid && item_ch.ready && item_ch.mode != MODE_INSTR) begin
                n = (item_ch.mode == MODE_MODIFY) ? 2 : 1;
                for (int k = 0; k < n; k++) begin
                    want.outcome        = cache_access(item_ch.address);
                    want.hit_total      = hits_q;
                    want.miss_total     = misses_q;
                    want.eviction_total = evicts_q;
                    want.last           = (k == n - 1);
                    expected_lookups.push_back(want);
                end
            end

            if (res_ch.valid && res_ch.ready) begin
                got.outcome        = res_ch.outcome;
                got.hit_total      = res_ch.hit_total;
                got.miss_total     = res_ch.miss_total;
                got.eviction_total = res_ch.eviction_total;
                got.last           = res_ch.last;
                if (expected_lookups.size() == 0) begin
                    flag($sformatf("unexpected result: outcome %0d counts %0d/%0d/%0d last %0b",
                        got.outcome, got.hit_total, got.miss_total, got.eviction_total,
                        got.last));
                end else begin
                    want = expected_lookups.pop_front();
                    checked++;
                    if (got.outcome !== want.outcome || got.hit_total !== want.hit_total ||
                        got.miss_total !== want.miss_total ||
                        got.eviction_total !== want.eviction_total ||
                        got.last !== want.last)
                        flag($sformatf({"lookup %0d: expected outcome %0d counts %0d/%0d/%0d",
                            " last %0b, got outcome %0d counts %0d/%0d/%0d last %0b"},
                            checked, want.outcome, want.hit_total, want.miss_total,
                            want.eviction_total, want.last, got.outcome, got.hit_total,
                            got.miss_total, got.eviction_total, got.last));
                end
            end
        end
        o_errors    <= errors;
        o_pending   <= expected_lookups.size();
        o_checked   <= checked;
        o_hits      <= hits_q;
        o_misses    <= misses_q;
        o_evictions <= evicts_q;
    end

endmodule

### dv/tb_set_assoc_lru_cache_tags.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_tags
// drives trace accesses and register writes into the lru tag store, with
// bursty sending and patterned result stalls; a checker beside the block
// predicts every lookup and this top gives the verdict
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_tags;
    import salc_pkg::*;

    localparam int MAX_SETS        = 64;
    localparam int WAYS            = 8;
    localparam int ADDR_BITS       = 32;
    // room for the row read and result registers plus one held stage, with margin
    localparam int SETTLE_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 65;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} t_stall;

    logic i_clk = 1'b0;
    logic i_rst_n;

    // register port
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    salc_item_if #(.ADDR_BITS(ADDR_BITS)) item_ch ();
    salc_result_if                        res_ch ();

    // checker outputs
    int     errors;
    int     pending;
    int     checked;
    t_count hit_sum;
    t_count miss_sum;
    t_count evict_sum;

    // sender state, touched only by the stimulus process
    logic valid_up      = 1'b0;
    int   gap_max       = 0;
    int   burst_left    = 1;
    int   items_sent    = 0;
    int   settings_done = 0;

    // receiver stall pattern
    t_stall      stall_style = STALL_NONE;
    logic [15:0] stall_pat   = 16'hffff;
    int          pat_pos     = 0;

    int idle_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    set_assoc_lru_cache_tags #(
        .MAX_SETS  (MAX_SETS),
        .WAYS      (WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (res_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    salc_lru_checker #(
        .MAX_SETS (MAX_SETS),
        .WAYS     (WAYS)
    ) lookup_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .item_ch     (item_ch),
        .res_ch      (res_ch),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_hits      (hit_sum),
        .o_misses    (miss_sum),
        .o_evictions (evict_sum)
    );

    // result stalls: a 16-bit pattern rotated each cycle and redrawn on
    // wrap, never all zero so a stall always ends
    always @(posedge i_clk) begin
        if (stall_style == STALL_NONE) begin
            res_ch.ready <= 1'b1;
        end else begin
            res_ch.ready <= stall_pat[0];
            if (pat_pos == 15) begin
                pat_pos   <= 0;
                stall_pat <= (stall_style == STALL_HEAVY) ?
                             ((16'($urandom()) & 16'($urandom())) | 16'h0001) :
                             (16'($urandom()) | 16'h0101);
            end else begin
                pat_pos   <= pat_pos + 1;
                stall_pat <= {stall_pat[0], stall_pat[15:1]};
            end
        end
    end

    // watchdog: any handshake on either channel or the register port counts
    // as progress
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles, %0d lookups outstanding",
                     idle_cycles, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // setup then access; the register takes the write on the access edge,
    // the wait after it keeps back-to-back writes from touching psel twice in a step
    task automatic apb_write(input t_reg_idx idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // every register written on each change of settings
    task automatic apply_settings(input int sb, input int bb, input int ways);
        apb_write(REG_SET_BITS, APB_DATA_W'(sb));
        apb_write(REG_BLOCK_BITS, APB_DATA_W'(bb));
        apb_write(REG_WAYS_USED, APB_DATA_W'(ways));
        settings_done++;
    endtask

    // one trace item; valid stays high inside a burst, drops for a random gap
    // at its end
    task automatic send_access(input t_mode m, input logic [31:0] a);
        item_ch.valid   <= 1'b1;
        item_ch.mode    <= m;
        item_ch.address <= a;
        valid_up = 1'b1;
        do @(posedge i_clk); while (!item_ch.ready);
        items_sent++;
        if (gap_max != 0) begin
            burst_left--;
            if (burst_left <= 0) begin
                item_ch.valid <= 1'b0;
                valid_up = 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
                burst_left = $urandom_range(1, 8);
            end
        end
    endtask

    // hold off until every predicted lookup is back, then wait out
    // SETTLE_CYCLES
    task automatic wait_idle();
        if (valid_up) begin
            item_ch.valid <= 1'b0;
            valid_up = 1'b0;
        end
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int          sb_sel;
        int          bb_sel;
        int          ways_sel;
        int          sb_use;
        int          nw_use;
        int          lookups_left;
        int          pick;
        t_mode       m;
        logic [31:0] addr;
        logic [63:0] wide;

        item_ch.valid   <= 1'b0;
        item_ch.mode    <= MODE_INSTR;
        item_ch.address <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        i_rst_n         <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: one set, one way, no offset
        send_access(MODE_INSTR, 32'h0000_0000);  // fetch leaves no trace
        send_access(MODE_LOAD, 32'h0000_0000);   // fill into empty way
        send_access(MODE_LOAD, 32'h0000_0000);   // hit
        send_access(MODE_STORE, 32'hffff_ffff);  // evict the only way
        send_access(MODE_MODIFY, 32'hffff_ffff); // hit twice
        send_access(MODE_MODIFY, 32'h8000_0001); // evict then hit
        send_access(MODE_INSTR, 32'hffff_ffff);
        wait_idle();

        // set bits above the limit saturate, widest offset leaves tag zero,
        // zero ways behaves as one
        apply_settings(7, 31, 0);
        send_access(MODE_LOAD, 32'h8000_0000);
        send_access(MODE_LOAD, 32'h0000_0000);
        send_access(MODE_STORE, 32'hffff_ffff);
        wait_idle();

        // a way taken out of use keeps its line: shrink to one way, refill,
        // grow back
        apply_settings(0, 0, 2);
        send_access(MODE_LOAD, 32'h0000_0010);
        send_access(MODE_LOAD, 32'h0000_0020);
        send_access(MODE_LOAD, 32'h0000_0010);
        wait_idle();
        apply_settings(0, 0, 1);
        send_access(MODE_LOAD, 32'h0000_0030);
        wait_idle();
        apply_settings(0, 0, 2);
        send_access(MODE_LOAD, 32'h0000_0020);   // way kept out of use still hits
        send_access(MODE_LOAD, 32'h0000_0040);   // older way goes
        send_access(MODE_LOAD, 32'h0000_0010);
        wait_idle();

        // ways above the array width act as all ways: overfill one set
        apply_settings(3, 4, 15);
        for (int t = 1; t <= 9; t++) begin
            send_access(MODE_STORE, 32'((t << 7) | (5 << 4) | t));
        end
        send_access(MODE_MODIFY, 32'((2 << 7) | (5 << 4)));
        wait_idle();

        // random part: first phases pin the extremes, later ones draw freely
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin sb_sel = 7; bb_sel = 31; ways_sel = 15; end
                1: begin sb_sel = 0; bb_sel = 0;  ways_sel = 1;  end
                2: begin sb_sel = 6; bb_sel = 26; ways_sel = 8;  end
                3: begin sb_sel = 0; bb_sel = 31; ways_sel = 0;  end
                4: begin sb_sel = 2; bb_sel = 4;  ways_sel = 4;  end
                default: begin
                    sb_sel   = $urandom_range(0, 7);
                    bb_sel   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) :
                               $urandom_range(0, 10);
                    ways_sel = $urandom_range(0, 15);
                end
            endcase
            apply_settings(sb_sel, bb_sel, ways_sel);
            sb_use = (sb_sel > $clog2(MAX_SETS)) ? $clog2(MAX_SETS) : sb_sel;
            nw_use = (ways_sel == 0) ? 1 : (ways_sel > WAYS) ? WAYS : ways_sel;

            // idling mix rotates so gaps and stalls land in every stage
            stall_style <= t_stall'(ph % 3);
            case ($urandom_range(0, 2))
                0:       gap_max = 0;
                1:       gap_max = 3;
                default: gap_max = 12;
            endcase
            burst_left   = $urandom_range(1, 8);
            lookups_left = ITEMS_PER_PHASE;

            while (lookups_left > 0) begin
                if ($urandom_range(0, 9) == 0) m = MODE_INSTR;
                else                           m = t_mode'($urandom_range(1, 3));
                // mostly a few tags on a few sets so lines get reused and
                // evicted; the rest full random or one flipped bit
                pick = $urandom_range(0, 99);
                if (pick < 20) begin
                    addr = $urandom();
                end else begin
                    wide = (64'($urandom_range(0, nw_use + 2)) << (bb_sel + sb_use)) |
                           ((64'($urandom_range(0, 3)) & ((64'd1 << sb_use) - 64'd1))
                               << bb_sel) |
                           (64'($urandom()) & ((64'd1 << bb_sel) - 64'd1));
                    if (pick < 30) wide = wide ^ (64'd1 << $urandom_range(0, 31));
                    addr = wide[31:0];
                end
                send_access(m, addr);
                if (m != MODE_INSTR) lookups_left--;
            end
            // sender waits for every result before the next settings
            wait_idle();
        end

        $display("covered %0d trace items over %0d register settings, %0d lookups checked",
                 items_sent, settings_done, checked);
        $display("final counts: %0d hits, %0d misses, %0d evictions",
                 hit_sum, miss_sum, evict_sum);
        if (pending != 0) $display("%0d predicted lookups never arrived", pending);
        if (errors == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
